// ----- rtl/core/pfe_pkg.sv -----
// Shared types, constants and symbol classification for the formula evaluator
`timescale 1ns / 1ps

package pfe_pkg;

  // stack sizing
  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OP_W        = 3;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // ascii codes
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // operator stack codes, higher code binds looser
  typedef enum logic [OP_W-1:0] {
    OP_END  = 3'd0,
    OP_NOT  = 3'd1,
    OP_AND  = 3'd2,
    OP_OR   = 3'd3,
    OP_IMP  = 3'd4,
    OP_EQV  = 3'd5,
    OP_OPEN = 3'd6
  } op_t;

  // classified symbol, operator codes share the low bits with op_t
  typedef enum logic [3:0] {
    SYM_END   = 4'd0,
    SYM_NOT   = 4'd1,
    SYM_AND   = 4'd2,
    SYM_OR    = 4'd3,
    SYM_IMP   = 4'd4,
    SYM_EQV   = 4'd5,
    SYM_OPEN  = 4'd6,
    SYM_CLOSE = 4'd7,
    SYM_BAD   = 4'd8,
    SYM_FALSE = 4'd9,
    SYM_TRUE  = 4'd10
  } sym_t;

  // one queued item
  typedef struct packed {
    sym_t sym;
    logic last;
  } item_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_APPLY,
    ST_EMIT
  } bk_state_t;

  // what the current operator does against the top of the operator stack
  typedef enum logic [2:0] {
    ACT_PUSH,
    ACT_POP_OPEN,
    ACT_REDUCE,
    ACT_FINISH,
    ACT_ERR
  } act_t;

  // map an ascii character to its symbol class
  function automatic sym_t classify(input logic [7:0] ch);
    sym_t s;
    unique case (ch)
      CH_BANG:   s = SYM_NOT;
      CH_CARET:  s = SYM_AND;
      CH_BAR:    s = SYM_OR;
      CH_GT:     s = SYM_IMP;
      CH_DASH:   s = SYM_EQV;
      CH_LPAREN: s = SYM_OPEN;
      CH_RPAREN: s = SYM_CLOSE;
      default: begin
        if ((ch >= CH_UP_A && ch <= CH_UP_Z) || (ch >= CH_LO_A && ch <= CH_LO_Z)) begin
          s = (ch == CH_T) ? SYM_TRUE : SYM_FALSE;
        end else begin
          s = SYM_BAD;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/propositional_formula_evaluator.sv -----
// Top level of the propositional formula evaluator
`timescale 1ns / 1ps

// Evaluates a propositional formula sent one ASCII character per item, with
// in_last_symbol marking the final character; one result item (truth value and
// malformed flag) follows each formula, after which the stacks start empty
// again. The front end registers, classifies and queues one item per cycle,
// while the queue has room, into a four-entry queue; the back end pushes a
// letter's value as it takes it from the queue, takes an operator or open
// parenthesis from the queue and then pushes it, takes a close parenthesis,
// pops the open and refills the cached top, and for every reduction a
// character triggers pops and reads the stack memories, then applies and
// refills the cached top. Closing a formula adds the reductions the end marker
// triggers, a step to match the end marker and a step to post the result; a
// result held by out_stall holds the back end. Each operator is pushed once
// and reduced once. After a malformed input the remaining characters of that
// formula are drained at one per cycle and the result reports malformed with
// truth value zero.
module propositional_formula_evaluator import pfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_last_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_truth_value,
  output logic       out_malformed
);

  logic  push, q_full, q_pop, q_empty;
  item_t push_item, q_head;

  // accept and classify
  pfe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  // decoupling queue
  pfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // evaluate
  pfe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_truth_value (out_truth_value),
    .out_malformed   (out_malformed)
  );

endmodule

// ----- rtl/core/pfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pfe_front.sv -----
// Front end: accepts characters, classifies them and hands them to the queue
`timescale 1ns / 1ps

module pfe_front import pfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_last_symbol,
  output logic       push,
  output item_t      push_item,
  input  logic       q_full
);

  logic  fr_valid_r, fr_valid_nxt;
  item_t fr_item_r, fr_item_nxt;
  logic  accept;

  // stall only while the holding register cannot drain
  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fr_valid_r && !q_full;
  assign push_item = fr_item_r;

  // holding register update
  always_comb begin
    fr_valid_nxt = accept || (fr_valid_r && q_full);
    fr_item_nxt  = fr_item_r;
    if (accept) begin
      fr_item_nxt.sym  = classify(in_symbol);
      fr_item_nxt.last = in_last_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_item_r <= fr_item_nxt;
  end

endmodule

// ----- rtl/core/pfe_queue.sv -----
// Short queue of classified items between front and back end
`timescale 1ns / 1ps

module pfe_queue import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  item_t              slots_r [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + Q_IDX_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + Q_IDX_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/pfe_back.sv -----
// Back end: two-stack operator-precedence evaluation and result register
`timescale 1ns / 1ps

module pfe_back import pfe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  item_t q_head,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output logic  out_truth_value,
  output logic  out_malformed
);

  bk_state_t        state_r, state_nxt;
  sym_t             cur_r, cur_nxt;
  logic             last_r, last_nxt;
  logic             err_r, err_nxt;
  logic [CNT_W-1:0] val_top_r, val_top_nxt;
  logic [CNT_W-1:0] op_top_r, op_top_nxt;
  logic             val_tos_r, val_tos_nxt;
  op_t              op_tos_r, op_tos_nxt;
  op_t              red_op_r, red_op_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_truth_r, out_truth_nxt;
  logic             out_malf_r, out_malf_nxt;

  // stack memories
  logic             vr_we, vr_wdata, vr_rdata;
  logic [IDX_W-1:0] vr_waddr, vr_raddr;
  logic             or_we;
  logic [OP_W-1:0]  or_wdata, or_rdata;
  logic [IDX_W-1:0] or_waddr, or_raddr;

  // decode
  op_t              top_op, cur_op;
  act_t             act;
  logic             val_ovf, op_ovf, red_err, out_load;
  logic             p_val, r_val;
  logic [CNT_W-1:0] val_m1, val_m2, op_m2;

  pfe_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (vr_we),
    .waddr (vr_waddr),
    .wdata (vr_wdata),
    .raddr (vr_raddr),
    .rdata (vr_rdata)
  );

  pfe_ram #(.WIDTH(OP_W), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (or_we),
    .waddr (or_waddr),
    .wdata (or_wdata),
    .raddr (or_raddr),
    .rdata (or_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_truth_value = out_truth_r;
  assign out_malformed   = out_malf_r;

  // stack top views and bounds
  assign top_op   = (op_top_r == CNT_W'(1)) ? OP_END : op_tos_r;
  assign cur_op   = op_t'(cur_r[OP_W-1:0]);
  assign val_ovf  = (val_top_r >= CNT_W'(STACK_DEPTH));
  assign op_ovf   = (op_top_r >= CNT_W'(STACK_DEPTH));
  assign red_err  = (top_op == OP_NOT) ? (val_top_r == '0) : (val_top_r < CNT_W'(2));
  assign out_load = !out_valid_r || !out_stall;
  assign val_m1   = val_top_r - CNT_W'(1);
  assign val_m2   = val_top_r - CNT_W'(2);
  assign op_m2    = op_top_r - CNT_W'(2);

  // precedence decision for the current operator
  always_comb begin
    unique case (cur_r)
      SYM_OPEN: begin
        act = op_ovf ? ACT_ERR : ACT_PUSH;
      end
      SYM_CLOSE: begin
        if (top_op == OP_END) begin
          act = ACT_ERR;
        end else if (top_op == OP_OPEN) begin
          act = ACT_POP_OPEN;
        end else begin
          act = red_err ? ACT_ERR : ACT_REDUCE;
        end
      end
      SYM_END: begin
        if (top_op == OP_END) begin
          act = (val_top_r == CNT_W'(1)) ? ACT_FINISH : ACT_ERR;
        end else if (top_op == OP_OPEN) begin
          act = ACT_ERR;
        end else begin
          act = red_err ? ACT_ERR : ACT_REDUCE;
        end
      end
      SYM_NOT, SYM_AND, SYM_OR, SYM_IMP, SYM_EQV: begin
        if (top_op == OP_END || top_op == OP_OPEN ||
            (top_op == OP_NOT && cur_op == OP_NOT) || top_op > cur_op) begin
          act = op_ovf ? ACT_ERR : ACT_PUSH;
        end else begin
          act = red_err ? ACT_ERR : ACT_REDUCE;
        end
      end
      default: act = ACT_ERR;
    endcase
  end

  // binary operator applied to the two top values
  assign p_val = vr_rdata;
  always_comb begin
    unique case (red_op_r)
      OP_AND:  r_val = p_val & val_tos_r;
      OP_OR:   r_val = p_val | val_tos_r;
      OP_IMP:  r_val = !p_val | val_tos_r;
      default: r_val = (p_val == val_tos_r);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (err_r) begin
            state_nxt = q_head.last ? ST_EMIT : ST_IDLE;
          end else begin
            unique case (q_head.sym)
              SYM_TRUE, SYM_FALSE: begin
                if (q_head.last) begin
                  state_nxt = val_ovf ? ST_EMIT : ST_DECIDE;
                end
              end
              SYM_NOT, SYM_AND, SYM_OR, SYM_IMP, SYM_EQV, SYM_OPEN, SYM_CLOSE: begin
                state_nxt = ST_DECIDE;
              end
              default: begin
                state_nxt = q_head.last ? ST_EMIT : ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_DECIDE: begin
        unique case (act)
          ACT_PUSH:     state_nxt = last_r ? ST_DECIDE : ST_IDLE;
          ACT_POP_OPEN: state_nxt = ST_APPLY;
          ACT_REDUCE:   state_nxt = ST_APPLY;
          ACT_FINISH:   state_nxt = ST_EMIT;
          default:      state_nxt = last_r ? ST_EMIT : ST_IDLE;
        endcase
      end
      ST_APPLY: begin
        if (red_op_r == OP_OPEN) begin
          state_nxt = last_r ? ST_DECIDE : ST_IDLE;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_EMIT: begin
        state_nxt = out_load ? ST_IDLE : ST_EMIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, stack ports and result register
  always_comb begin
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    val_top_nxt   = val_top_r;
    op_top_nxt    = op_top_r;
    val_tos_nxt   = val_tos_r;
    op_tos_nxt    = op_tos_r;
    red_op_nxt    = red_op_r;
    out_truth_nxt = out_truth_r;
    out_malf_nxt  = out_malf_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    vr_we         = 1'b0;
    vr_waddr      = '0;
    vr_wdata      = 1'b0;
    vr_raddr      = '0;
    or_we         = 1'b0;
    or_waddr      = '0;
    or_wdata      = '0;
    or_raddr      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          last_nxt = q_head.last;
          if (!err_r) begin
            unique case (q_head.sym)
              SYM_TRUE, SYM_FALSE: begin
                if (val_ovf) begin
                  err_nxt = 1'b1;
                end else begin
                  vr_we       = 1'b1;
                  vr_waddr    = val_top_r[IDX_W-1:0];
                  vr_wdata    = (q_head.sym == SYM_TRUE);
                  val_tos_nxt = (q_head.sym == SYM_TRUE);
                  val_top_nxt = val_top_r + CNT_W'(1);
                end
                if (q_head.last) begin
                  cur_nxt = SYM_END;
                end
              end
              SYM_NOT, SYM_AND, SYM_OR, SYM_IMP, SYM_EQV, SYM_OPEN, SYM_CLOSE: begin
                cur_nxt = q_head.sym;
              end
              default: begin
                err_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      ST_DECIDE: begin
        unique case (act)
          ACT_PUSH: begin
            or_we      = 1'b1;
            or_waddr   = op_top_r[IDX_W-1:0];
            or_wdata   = cur_op;
            op_tos_nxt = cur_op;
            op_top_nxt = op_top_r + CNT_W'(1);
            if (last_r) begin
              cur_nxt = SYM_END;
            end
          end
          ACT_POP_OPEN: begin
            op_top_nxt = op_top_r - CNT_W'(1);
            or_raddr   = op_m2[IDX_W-1:0];
            red_op_nxt = OP_OPEN;
          end
          ACT_REDUCE: begin
            op_top_nxt = op_top_r - CNT_W'(1);
            or_raddr   = op_m2[IDX_W-1:0];
            red_op_nxt = top_op;
            if (top_op == OP_NOT) begin
              vr_we       = 1'b1;
              vr_waddr    = val_m1[IDX_W-1:0];
              vr_wdata    = !val_tos_r;
              val_tos_nxt = !val_tos_r;
            end else begin
              vr_raddr = val_m2[IDX_W-1:0];
            end
          end
          ACT_FINISH: begin
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
      ST_APPLY: begin
        // refill the cached operator top after the pop
        op_tos_nxt = op_t'(or_rdata);
        unique case (red_op_r)
          OP_AND, OP_OR, OP_IMP, OP_EQV: begin
            vr_we       = 1'b1;
            vr_waddr    = val_m2[IDX_W-1:0];
            vr_wdata    = r_val;
            val_tos_nxt = r_val;
            val_top_nxt = val_top_r - CNT_W'(1);
          end
          OP_OPEN: begin
            if (last_r) begin
              cur_nxt = SYM_END;
            end
          end
          default: begin
          end
        endcase
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_truth_nxt = !err_r && val_tos_r;
          out_malf_nxt  = err_r;
          err_nxt       = 1'b0;
          val_top_nxt   = '0;
          op_top_nxt    = CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= 1'b0;
      val_top_r   <= '0;
      op_top_r    <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      val_top_r   <= val_top_nxt;
      op_top_r    <= op_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    last_r      <= last_nxt;
    val_tos_r   <= val_tos_nxt;
    op_tos_r    <= op_tos_nxt;
    red_op_r    <= red_op_nxt;
    out_truth_r <= out_truth_nxt;
    out_malf_r  <= out_malf_nxt;
  end

  // operator stack always keeps the end marker and stays in bounds
  a_op_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    op_top_r != '0 && op_top_r <= CNT_W'(STACK_DEPTH))
    else $error("operator stack pointer out of range");

  // a delivered result leaves the stacks and error flag cleared
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_load) |=>
      (!err_r && val_top_r == '0 && op_top_r == CNT_W'(1) && out_valid_r))
    else $error("stacks not cleared after result");

  // apply only follows a pop issued in decide
  a_apply_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |-> $past(state_r) == ST_DECIDE)
    else $error("apply entered without a pop");

endmodule
